FILE: rtl/rpe_pkg.sv
// rotary position embedding: shared widths, register codes and result entry type
// no dependencies; imported by the channel interfaces, the top-level rtl module and the testbench
package rpe_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int TRIG_W   = 16;
  localparam int IDX_W    = 8;
  localparam int FRAC_W   = 14;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int HALF_W     = 7;
  localparam int LEN_W      = 9;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_ROT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MODE = 2'd2;

  localparam logic [HALF_W-1:0] HALF_ROT_RST = 7'd32;
  localparam logic [LEN_W-1:0]  HEAD_LEN_RST = 9'd64;

  // pending pair buffer word: {x, cos, sin}
  localparam int PEND_W = SAMPLE_W + 2 * TRIG_W;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  // one queue entry holds one pass-through result or both results of a pair
  typedef struct packed {
    logic [SAMPLE_W-1:0] v0;
    logic [IDX_W-1:0]    i0;
    logic [SAMPLE_W-1:0] v1;
    logic [IDX_W-1:0]    i1;
    logic                pair;
    logic                done;
  } rpe_entry_t;

endpackage

FILE: rtl/rpe_if.sv
// valid/ready channel interfaces for input items and result items
// depends on rpe_pkg for the field widths
interface rpe_in_if
  import rpe_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [TRIG_W-1:0]   cos_val;
  logic signed [TRIG_W-1:0]   sin_val;

  modport source (output valid, output sample, output cos_val, output sin_val, input ready);
  modport sink   (input valid, input sample, input cos_val, input sin_val, output ready);
endinterface

interface rpe_out_if
  import rpe_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_value;
  logic [IDX_W-1:0]           out_index;
  logic                       head_done;

  modport source (output valid, output out_value, output out_index, output head_done,
                  input ready);
  modport sink   (input valid, input out_value, input out_index, input head_done,
                  output ready);
endinterface

FILE: rtl/rotary_position_embedding_unit.sv
// rotary position embedding over a stream of head elements
// an accepted item passes stage 1, stage 2 and the result queue before its first result on dout
// a new item is taken while the result queue has room; the result port emits one result per cycle
// while dout is ready, the two results of a pair one after the other
// reset: registers to half_rot 32, head_len 64, split mode; element count and queue
// cleared; pair buffer ram is not cleared
module rotary_position_embedding_unit
  import rpe_pkg::*;
#(
  parameter int MAX_HALF = 64,
  parameter int MAX_HEAD = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rpe_in_if.sink                din,
  rpe_out_if.source             dout
);

  localparam int SLOT_W  = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;
  localparam int POS_W   = $clog2(MAX_HEAD);
  localparam int HL_W    = $clog2(MAX_HEAD + 1);
  localparam int AW      = ((HL_W > LEN_W) ? HL_W : LEN_W) + 1;
  localparam int PROD_W  = 2 * SAMPLE_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int RES_CNT = RQ_CNT_W;

  // configuration registers
  logic [HALF_W-1:0] half_rot;
  logic [LEN_W-1:0]  head_len;
  logic              split_half_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_rot        <= HALF_ROT_RST;
      head_len        <= HEAD_LEN_RST;
      split_half_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_ROT:   half_rot        <= cfg_data[HALF_W-1:0];
        REG_HEAD_LEN:   head_len        <= cfg_data[LEN_W-1:0];
        REG_SPLIT_MODE: split_half_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective span and head length
  logic [AW-1:0] len_eff, half_cap, half_eff;

  always_comb begin
    len_eff  = ((head_len == '0) || (AW'(head_len) > AW'(MAX_HEAD))) ? AW'(MAX_HEAD)
                                                                      : AW'(head_len);
    half_cap = (AW'(half_rot) > AW'(MAX_HALF)) ? AW'(MAX_HALF) : AW'(half_rot);
    half_eff = ((half_cap << 1) > len_eff) ? (len_eff >> 1) : half_cap;
  end

  // element position and pair decode
  logic [POS_W-1:0] pos;
  logic [AW-1:0]    pos_w, slot, xi, yi;
  logic             in_span, second, done, accept, produce;

  always_comb begin
    pos_w   = AW'(pos);
    in_span = pos_w < (half_eff << 1);
    done    = (pos_w + AW'(1)) >= len_eff;
    if (split_half_mode) begin
      second = pos_w >= half_eff;
      slot   = second ? (pos_w - half_eff) : pos_w;
      xi     = slot;
      yi     = half_eff + slot;
    end else begin
      second = pos[0];
      slot   = pos_w >> 1;
      xi     = slot << 1;
      yi     = (slot << 1) + AW'(1);
    end
  end

  // queue entries reserved, including those for items still in the pipeline
  logic [RES_CNT-1:0] reserved;
  logic               pop_entry;

  assign din.ready = reserved < RES_CNT'(RQ_DEPTH);
  assign accept    = din.valid && din.ready;
  assign produce   = !in_span || second;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= done ? '0 : POS_W'(pos_w + AW'(1));
    end
  end

  // pair buffer: first element writes its slot, the completing element reads it;
  // the write lands at the accept edge, so a later read always sees it
  logic [PEND_W-1:0] pend_rdata;

  rpe_ram #(
    .WIDTH (PEND_W),
    .DEPTH (MAX_HALF)
  ) u_pend_ram (
    .clk   (clk),
    .we    (accept && in_span && !second),
    .waddr (SLOT_W'(slot)),
    .wdata ({din.sample, din.cos_val, din.sin_val}),
    .re    (accept && in_span && second),
    .raddr (SLOT_W'(slot)),
    .rdata (pend_rdata)
  );

  // stage 1: item fields wait for the buffer read
  logic                s1_valid, s1_pair, s1_done;
  logic [SAMPLE_W-1:0] s1_y;
  logic [IDX_W-1:0]    s1_xi, s1_yi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    s1_pair <= in_span;
    s1_done <= done;
    s1_y    <= din.sample;
    s1_xi   <= in_span ? IDX_W'(xi) : IDX_W'(pos_w);
    s1_yi   <= IDX_W'(yi);
  end

  // stage 2: the four products
  logic signed [SAMPLE_W-1:0] pend_x;
  logic signed [TRIG_W-1:0]   pend_c, pend_s;
  logic signed [PROD_W-1:0]   p_xc, p_ys, p_yc, p_xs;
  logic                       s2_valid, s2_pair, s2_done;
  logic [SAMPLE_W-1:0]        s2_y;
  logic [IDX_W-1:0]           s2_xi, s2_yi;

  assign pend_x = $signed(pend_rdata[PEND_W-1 -: SAMPLE_W]);
  assign pend_c = $signed(pend_rdata[2*TRIG_W-1 -: TRIG_W]);
  assign pend_s = $signed(pend_rdata[TRIG_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_xc    <= pend_x * pend_c;
    p_ys    <= $signed(s1_y) * pend_s;
    p_yc    <= $signed(s1_y) * pend_c;
    p_xs    <= pend_x * pend_s;
    s2_pair <= s1_pair;
    s2_done <= s1_done;
    s2_y    <= s1_y;
    s2_xi   <= s1_xi;
    s2_yi   <= s1_yi;
  end

  // round half up at the binary point, then saturate to the sample range
  function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] q;
    q = (acc + ACC_W'(signed'(1 <<< (FRAC_W - 1)))) >>> FRAC_W;
    if (q > ACC_W'(signed'(32767))) begin
      return SAMPLE_W'(16'h7fff);
    end else if (q < -ACC_W'(signed'(32768))) begin
      return SAMPLE_W'(16'h8000);
    end
    return q[SAMPLE_W-1:0];
  endfunction

  // stage 3: sums and rounding form one queue entry
  rpe_entry_t new_entry;

  always_comb begin
    new_entry.pair = s2_pair;
    new_entry.done = s2_done;
    new_entry.i0   = s2_xi;
    new_entry.i1   = s2_yi;
    new_entry.v0   = s2_pair ? round_sat(ACC_W'(p_xc) - ACC_W'(p_ys)) : s2_y;
    new_entry.v1   = round_sat(ACC_W'(p_yc) + ACC_W'(p_xs));
  end

  // result queue; a pair entry leaves as two results, first v0 then v1
  rpe_entry_t          rq [RQ_DEPTH];
  rpe_entry_t          head;
  logic [RQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RQ_CNT_W-1:0] rq_count;
  logic                sub;

  assign head         = rq[rd_ptr];
  assign dout.valid   = rq_count != '0;
  assign dout.out_value = (head.pair && sub) ? head.v1 : head.v0;
  assign dout.out_index = (head.pair && sub) ? head.i1 : head.i0;
  assign dout.head_done = head.done && (!head.pair || sub);
  assign pop_entry    = dout.valid && dout.ready && (!head.pair || sub);

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      rq[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      rq_count <= '0;
      sub      <= 1'b0;
      reserved <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + RQ_PTR_W'(1);
      end
      if (pop_entry) begin
        rd_ptr <= rd_ptr + RQ_PTR_W'(1);
      end
      rq_count <= rq_count + RQ_CNT_W'(s2_valid) - RQ_CNT_W'(pop_entry);
      reserved <= reserved + RES_CNT'(accept && produce) - RES_CNT'(pop_entry);
      if (dout.valid && dout.ready) begin
        sub <= head.pair && !sub;
      end
    end
  end

endmodule

FILE: rtl/rpe_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rpe_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: dv/testbench.sv
// testbench for rotary_position_embedding_unit: a table of directed rows, then random heads
// needs rpe_pkg, the rpe_in_if / rpe_out_if channels and the rtl top level
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpe_pkg::*;

  localparam int MAX_HALF      = 64;
  localparam int MAX_HEAD      = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int TOTAL_ITEMS   = 25 + 1450;
  localparam int MAX_REPORTS   = 10;
  localparam int NUM_ROWS      = 31;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_TYPED} row_kind_t;

  // item rows: a/b/c are sample, cos, sin; register rows: half_rot, head_len, split mode
  // typed rows carry their expected results in nexp and v/i/d
  typedef struct {
    row_kind_t kind;
    int        a, b, c;
    int        nexp;
    int        v0, i0, d0;
    int        v1, i1, d1;
  } stim_row_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic [IDX_W-1:0]           index;
    logic                       last;
  } elem_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rpe_in_if  din_ch ();
  rpe_out_if dout_ch ();

  rotary_position_embedding_unit #(
    .MAX_HALF (MAX_HALF),
    .MAX_HEAD (MAX_HEAD)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_ch.sink),
    .dout      (dout_ch.source)
  );

  // mirrored registers and element state
  int unsigned reg_half;
  int unsigned reg_len;
  bit          reg_split;
  int unsigned elem_pos;
  logic signed [SAMPLE_W-1:0] held_x   [MAX_HALF];
  logic signed [TRIG_W-1:0]   held_cos [MAX_HALF];
  logic signed [TRIG_W-1:0]   held_sin [MAX_HALF];

  elem_result_t due_elements [$];
  int          error_count    = 0;
  int          items_sent     = 0;
  int unsigned cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          sink_stall_pct = 0;

  // corner register settings for the first random phases: {half_rot, head_len, split}
  int corner_cfg [5][3] = '{
    '{64, 0, 1}, '{7, 511, 0}, '{64, 128, 0}, '{1, 2, 1}, '{127, 130, 1}
  };

  stim_row_t directed_rows [NUM_ROWS] = '{
    // split pairs, then pass-through up to the head end
    '{ROW_CFG,   2, 6, 1,               0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, 1000, 16384, 0,        0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, -32768, 16384, -16384, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, 2000, 123, -77,        2, 1000, 0, 0, 2000, 2, 0},
    '{ROW_TYPED, 32767, 5, 5,           2, -1, 1, 0, 32767, 3, 0},
    '{ROW_TYPED, -32768, 16384, -16384, 1, -32768, 4, 0, 0, 0, 0},
    '{ROW_TYPED, 32767, -16384, 16384,  1, 32767, 5, 1, 0, 0, 0},
    // adjacent pairs: rounding of halves, saturation, odd element left over
    '{ROW_CFG,   3, 7, 0,               0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, 1, 8192, 0,            0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, 0, 0, 0,               2, 1, 0, 0, 0, 1, 0},
    '{ROW_TYPED, -1, 8192, 0,           0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, 0, 0, 0,               2, 0, 2, 0, 0, 3, 0},
    '{ROW_TYPED, -32768, -16384, 16384, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, -32768, 0, 0,          2, 32767, 4, 0, 0, 5, 0},
    '{ROW_TYPED, 12345, 1, -1,          1, 12345, 6, 1, 0, 0, 0},
    // no rotation at all
    '{ROW_CFG,   0, 3, 1,               0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, -1, 16384, -16384,     1, -1, 0, 0, 0, 0, 0},
    '{ROW_TYPED, 21845, -16384, 16384,  1, 21845, 1, 0, 0, 0, 0},
    '{ROW_TYPED, -21846, 0, 0,          1, -21846, 2, 1, 0, 0, 0},
    // oversized half clipped, then shortened by the head length
    '{ROW_CFG,   127, 4, 1,             0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  -32768, 16384, 16384,  0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  32767, -16384, -1,     0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  -32768, 9000, 3,       0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  12345, -5, 7,          0, 0, 0, 0, 0, 0, 0},
    // head length cut below the count mid-head: next element ends the head
    '{ROW_CFG,   1, 8, 0,               0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  300, 11585, 11585,     0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  -300, 0, 0,            0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  7, 0, 0,               0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  -7, 0, 0,              0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG,   1, 3, 0,               0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, 32512, 0, 0,           1, 32512, 4, 1, 0, 0, 0}
  };

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // round a q.14 sum half up, saturate to the sample range
  function automatic logic signed [SAMPLE_W-1:0] round_q14(input longint acc);
    longint q;
    q = (acc + 64'sd8192) >>> 14;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[SAMPLE_W-1:0];
  endfunction

  // rotation of one element: buffers first pair elements, returns result count
  function automatic int rotate_element(input logic signed [SAMPLE_W-1:0] s,
                                        input logic signed [TRIG_W-1:0] c,
                                        input logic signed [TRIG_W-1:0] n,
                                        output elem_result_t r0, output elem_result_t r1);
    int unsigned len, half, pos, slot, xi, yi;
    bit          second, last;
    longint      x, y, cs, sn;
    int          nres;
    len  = reg_len;
    half = reg_half;
    pos  = elem_pos;
    nres = 0;
    r0   = '{'0, '0, 1'b0};
    r1   = '{'0, '0, 1'b0};
    if (len == 0 || len > MAX_HEAD) len = MAX_HEAD;
    if (half > MAX_HALF) half = MAX_HALF;
    if (2 * half > len) half = len / 2;
    last = (pos + 1 >= len);
    if (pos < 2 * half) begin
      if (reg_split) begin
        second = (pos >= half);
        slot   = second ? pos - half : pos;
        xi     = slot;
        yi     = half + slot;
      end else begin
        second = (pos % 2) == 1;
        slot   = pos / 2;
        xi     = 2 * slot;
        yi     = xi + 1;
      end
      if (!second) begin
        held_x[slot]   = s;
        held_cos[slot] = c;
        held_sin[slot] = n;
      end else begin
        x  = held_x[slot];
        cs = held_cos[slot];
        sn = held_sin[slot];
        y  = s;
        r0 = '{round_q14(x * cs - y * sn), IDX_W'(xi), 1'b0};
        r1 = '{round_q14(y * cs + x * sn), IDX_W'(yi), last};
        nres = 2;
      end
    end else begin
      r0   = '{s, IDX_W'(pos), last};
      nres = 1;
    end
    elem_pos = last ? 0 : pos + 1;
    return nres;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(7))
      0: return 32767;
      1: return -32768;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic int rand_trig();
    case ($urandom_range(7))
      0: return 16384;
      1: return -16384;
      2: return 0;
      default: return int'($urandom_range(32768)) - 16384;
    endcase
  endfunction

  // offer one item, book its expected results once it is taken
  task automatic send_item(input stim_row_t row);
    elem_result_t r0, r1;
    int           nres;
    while ($urandom_range(99) < send_idle_pct) begin
      din_ch.valid <= 1'b0;
      @(posedge clk);
    end
    din_ch.valid   <= 1'b1;
    din_ch.sample  <= SAMPLE_W'(row.a);
    din_ch.cos_val <= TRIG_W'(row.b);
    din_ch.sin_val <= TRIG_W'(row.c);
    do @(posedge clk); while (din_ch.ready !== 1'b1);
    nres = rotate_element(SAMPLE_W'(row.a), TRIG_W'(row.b), TRIG_W'(row.c), r0, r1);
    if (row.kind == ROW_TYPED) begin
      nres = row.nexp;
      r0   = '{SAMPLE_W'(row.v0), IDX_W'(row.i0), row.d0 != 0};
      r1   = '{SAMPLE_W'(row.v1), IDX_W'(row.i1), row.d1 != 0};
    end
    if (nres > 0) due_elements.push_back(r0);
    if (nres > 1) due_elements.push_back(r1);
    items_sent++;
  endtask

  // stop sending and wait until every booked result is out
  task automatic drain(input int pad);
    din_ch.valid <= 1'b0;
    do @(posedge clk); while (due_elements.size() != 0);
    repeat (pad) @(posedge clk);
  endtask

  // write all three registers on consecutive cycles
  task automatic set_regs(input int half, input int len, input int mode);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_ROT;
    cfg_data  <= CFG_DATA_W'(half);
    @(posedge clk);
    cfg_index <= REG_HEAD_LEN;
    cfg_data  <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_index <= REG_SPLIT_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_we    <= 1'b0;
    reg_half  = half % (1 << HALF_W);
    reg_len   = len % (1 << LEN_W);
    reg_split = mode % 2;
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%t %s", $realtime, msg);
  endtask

  // result sink: random stalls, compare against the oldest booked result
  always @(posedge clk) begin : take_results
    elem_result_t want;
    if (rst) begin
      dout_ch.ready <= 1'b0;
    end else begin
      if (dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1) begin
        if (due_elements.size() == 0) begin
          report_error($sformatf("unexpected result: value %0d index %0d done %0b",
                                 dout_ch.out_value, dout_ch.out_index, dout_ch.head_done));
        end else begin
          want = due_elements.pop_front();
          if (dout_ch.out_value !== want.value || dout_ch.out_index !== want.index ||
              dout_ch.head_done !== want.last) begin
            report_error($sformatf(
              "mismatch: expected value %0d index %0d done %0b, got %0d %0d %0b",
              want.value, want.index, want.last,
              dout_ch.out_value, dout_ch.out_index, dout_ch.head_done));
          end
        end
      end
      dout_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int half, len, mode, eff, heads, phase;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    din_ch.valid   = 1'b0;
    din_ch.sample  = '0;
    din_ch.cos_val = '0;
    din_ch.sin_val = '0;
    dout_ch.ready  = 1'b0;
    reg_half       = HALF_ROT_RST;
    reg_len        = HEAD_LEN_RST;
    reg_split      = 1'b1;
    elem_pos       = 0;
    for (int k = 0; k < MAX_HALF; k++) begin
      held_x[k]   = '0;
      held_cos[k] = '0;
      held_sin[k] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        drain(SETTLE_CYCLES);
        set_regs(directed_rows[k].a, directed_rows[k].b, directed_rows[k].c);
      end else begin
        send_item(directed_rows[k]);
      end
    end

    // random phases of whole heads, corner settings first
    for (phase = 0; items_sent < TOTAL_ITEMS; phase++) begin
      if (phase < 5) begin
        half = corner_cfg[phase][0];
        len  = corner_cfg[phase][1];
        mode = corner_cfg[phase][2];
      end else if ($urandom_range(9) == 0) begin
        half = $urandom_range(127);
        len  = $urandom_range(90, 25);
        mode = $urandom_range(1);
      end else begin
        half = $urandom_range(10);
        len  = $urandom_range(24, 2);
        mode = $urandom_range(1);
      end
      drain(SETTLE_CYCLES);
      set_regs(half, len, mode);
      case (phase % 4)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 67; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 67; end
        default: begin send_idle_pct = 35; sink_stall_pct = 35; end
      endcase
      eff   = (len == 0 || len > MAX_HEAD) ? MAX_HEAD : len;
      heads = (eff >= 48) ? 1 : 48 / eff;
      repeat (heads * eff) begin
        // now and then hold off until the block has emptied
        if ($urandom_range(39) == 0) drain(0);
        send_item('{ROW_ITEM, rand_sample(), rand_trig(), rand_trig(),
                    0, 0, 0, 0, 0, 0, 0});
      end
    end

    drain(END_CYCLES);
    if (error_count == 0 && due_elements.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
